### rtl/thlpg_pkg.sv
// Shared types and constants for the thick line point generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package thlpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CORNER_BITS = COORD_BITS + 1;
  localparam int SPAN_BITS   = COORD_BITS + 1;   // signed negated span
  localparam int ERR_BITS    = COORD_BITS + 2;   // Bresenham error term
  localparam int BRUSH_BITS  = 6;
  localparam int COLOR_BITS  = 24;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [CORNER_BITS-1:0] corner_t;
  typedef logic signed [SPAN_BITS-1:0]   nspan_t;
  typedef logic signed [ERR_BITS-1:0]    err_t;
  typedef logic        [COORD_BITS-1:0]  span_t;
  typedef logic        [BRUSH_BITS-1:0]  brush_t;
  typedef logic        [COLOR_BITS-1:0]  color_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // One emitted point with its brush square.
  typedef struct packed {
    coord_t  point_x;
    coord_t  point_y;
    corner_t corner_x;
    corner_t corner_y;
    brush_t  brush;
    color_t  color;
    logic    last;
  } result_t;

endpackage

### rtl/thick_line_point_generator.sv
// Top level of the thick line point generator.
// Depends on thlpg_pkg, thlpg_walker and thlpg_out_reg.
`timescale 1ns / 1ps

// All-octant integer Bresenham line walker with a square brush. A start
// request (command 0) loads both endpoints, the brush side and the colour
// and emits the first point; each step request (command 1) advances one
// point and emits it. The point equal to the end point carries out_last;
// steps after that, or before any start, are accepted and give no result.
// A start always abandons any line in progress. Each result also gives the
// brush square corner, point minus brush/2 rounded down. Throughput is one
// request per cycle while in_ready is high: the walker state updates at the
// end of the accepting cycle and the point is loaded into a single output
// register at the same clock edge. in_ready is low only while that register
// holds a point the downstream side is not taking.

module thick_line_point_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [thlpg_pkg::COORD_BITS-1:0]  in_start_x,
  input  logic [thlpg_pkg::COORD_BITS-1:0]  in_start_y,
  input  logic [thlpg_pkg::COORD_BITS-1:0]  in_end_x,
  input  logic [thlpg_pkg::COORD_BITS-1:0]  in_end_y,
  input  logic [thlpg_pkg::BRUSH_BITS-1:0]  in_brush,
  input  logic [thlpg_pkg::COLOR_BITS-1:0]  in_paint,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [thlpg_pkg::COORD_BITS-1:0]  out_point_x,
  output logic [thlpg_pkg::COORD_BITS-1:0]  out_point_y,
  output logic [thlpg_pkg::CORNER_BITS-1:0] out_corner_x,
  output logic [thlpg_pkg::CORNER_BITS-1:0] out_corner_y,
  output logic [thlpg_pkg::BRUSH_BITS-1:0]  out_brush_out,
  output logic [thlpg_pkg::COLOR_BITS-1:0]  out_color_out,
  output logic                       out_last
);
  import thlpg_pkg::*;

  logic    take;     // request accepted
  logic    emit;     // request makes a point
  logic    free;
  result_t res_new;
  result_t res_q;
  cmd_t    cmd;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = free;
  assign take     = in_valid && free;

  thlpg_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .command (cmd),
    .start_x (coord_t'(in_start_x)),
    .start_y (coord_t'(in_start_y)),
    .end_x   (coord_t'(in_end_x)),
    .end_y   (coord_t'(in_end_y)),
    .brush   (in_brush),
    .paint   (in_paint),
    .emit    (emit),
    .res     (res_new)
  );

  // a step when idle is consumed silently: nothing is loaded
  thlpg_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && emit),
    .res_in    (res_new),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_point_x   = res_q.point_x;
  assign out_point_y   = res_q.point_y;
  assign out_corner_x  = res_q.corner_x;
  assign out_corner_y  = res_q.corner_y;
  assign out_brush_out = res_q.brush;
  assign out_color_out = res_q.color;
  assign out_last      = res_q.last;

endmodule

### rtl/thlpg_walker.sv
// Line walker: holds the Bresenham state and forms the point for each request.
// Depends on thlpg_pkg.
`timescale 1ns / 1ps

module thlpg_walker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,      // request accepted this cycle
  input  thlpg_pkg::cmd_t   command,
  input  thlpg_pkg::coord_t start_x,
  input  thlpg_pkg::coord_t start_y,
  input  thlpg_pkg::coord_t end_x,
  input  thlpg_pkg::coord_t end_y,
  input  thlpg_pkg::brush_t brush,
  input  thlpg_pkg::color_t paint,
  output logic              emit,      // request produces a point
  output thlpg_pkg::result_t res
);
  import thlpg_pkg::*;

  coord_t cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  span_t  span_x_r;
  nspan_t neg_span_y_r;
  logic   dir_x_r, dir_y_r, finished_r;
  err_t   err_acc_r;
  brush_t brush_r;
  color_t color_r;

  coord_t cur_x_nxt, cur_y_nxt, goal_x_nxt, goal_y_nxt;
  span_t  span_x_nxt;
  nspan_t neg_span_y_nxt;
  logic   dir_x_nxt, dir_y_nxt, finished_nxt;
  err_t   err_acc_nxt;
  brush_t brush_nxt;
  color_t color_nxt;

  // start path
  logic signed [COORD_BITS:0] dx, dy;
  span_t  sx, sy;
  // step path
  logic signed [ERR_BITS:0] twice;
  logic   mv_x, mv_y;
  err_t   err_step;
  logic   at_end;
  corner_t half;

  assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign sx = dx[COORD_BITS] ? span_t'(-dx) : span_t'(dx);
  assign sy = dy[COORD_BITS] ? span_t'(-dy) : span_t'(dy);

  assign twice = {err_acc_r, 1'b0};
  assign mv_x  = twice >= (ERR_BITS+1)'(neg_span_y_r);
  assign mv_y  = twice <= $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, span_x_r});
  assign err_step = err_acc_r
                  + (mv_x ? ERR_BITS'(neg_span_y_r) : '0)
                  + (mv_y ? $signed({{(ERR_BITS-COORD_BITS){1'b0}}, span_x_r}) : '0);

  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    span_x_nxt     = span_x_r;
    neg_span_y_nxt = neg_span_y_r;
    dir_x_nxt      = dir_x_r;
    dir_y_nxt      = dir_y_r;
    err_acc_nxt    = err_acc_r;
    brush_nxt      = brush_r;
    color_nxt      = color_r;
    emit           = 1'b0;
    if (command == CMD_START) begin
      cur_x_nxt      = start_x;
      cur_y_nxt      = start_y;
      goal_x_nxt     = end_x;
      goal_y_nxt     = end_y;
      span_x_nxt     = sx;
      neg_span_y_nxt = -$signed({1'b0, sy});
      dir_x_nxt      = start_x < end_x;
      dir_y_nxt      = start_y < end_y;
      err_acc_nxt    = $signed({2'b00, sx}) - $signed({2'b00, sy});
      brush_nxt      = brush;
      color_nxt      = paint;
      emit           = 1'b1;
    end else if (!finished_r) begin
      if (mv_x) cur_x_nxt = dir_x_r ? cur_x_r + coord_t'(1) : cur_x_r - coord_t'(1);
      if (mv_y) cur_y_nxt = dir_y_r ? cur_y_r + coord_t'(1) : cur_y_r - coord_t'(1);
      err_acc_nxt = err_step;
      emit        = 1'b1;
    end
  end

  assign at_end       = (cur_x_nxt == goal_x_nxt) && (cur_y_nxt == goal_y_nxt);
  assign finished_nxt = emit ? at_end : finished_r;
  assign half         = $signed({{(CORNER_BITS-BRUSH_BITS+1){1'b0}},
                                 brush_nxt[BRUSH_BITS-1:1]});

  always_comb begin
    res.point_x  = cur_x_nxt;
    res.point_y  = cur_y_nxt;
    res.corner_x = $signed({cur_x_nxt[COORD_BITS-1], cur_x_nxt}) - half;
    res.corner_y = $signed({cur_y_nxt[COORD_BITS-1], cur_y_nxt}) - half;
    res.brush    = brush_nxt;
    res.color    = color_nxt;
    res.last     = at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      span_x_r     <= '0;
      neg_span_y_r <= '0;
      dir_x_r      <= 1'b0;
      dir_y_r      <= 1'b0;
      err_acc_r    <= '0;
      finished_r   <= 1'b1;
      brush_r      <= '0;
      color_r      <= '0;
    end else if (take) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      span_x_r     <= span_x_nxt;
      neg_span_y_r <= neg_span_y_nxt;
      dir_x_r      <= dir_x_nxt;
      dir_y_r      <= dir_y_nxt;
      err_acc_r    <= err_acc_nxt;
      finished_r   <= finished_nxt;
      brush_r      <= brush_nxt;
      color_r      <= color_nxt;
    end
  end

endmodule

### rtl/thlpg_out_reg.sv
// Result register: holds one point until the downstream side takes it.
// Depends on thlpg_pkg.
`timescale 1ns / 1ps

module thlpg_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,     // new point this cycle
  input  thlpg_pkg::result_t res_in,
  output logic               free,     // register can take a point now
  output logic               out_valid,
  input  logic               out_ready,
  output thlpg_pkg::result_t res_out
);
  import thlpg_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

endmodule
